FILE: rtl/page_valid_range_tracker_assert.svh
// ----------------------------------------------------------------------------
// Page valid range tracker assertion macros
// Clocked on clk and disabled while rst_n is low; the using module must have
// both signals in scope.
// ----------------------------------------------------------------------------
`ifndef PAGE_VALID_RANGE_TRACKER_ASSERT_SVH
`define PAGE_VALID_RANGE_TRACKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PVRT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PVRT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/pvrt_pkg.sv
// ----------------------------------------------------------------------------
// pvrt_pkg
// Shared constants, codes and types of the page valid range tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package pvrt_pkg;

    localparam int PAGE_SAMPLES = 1024;
    localparam int PAGE_COUNT   = 1024;

    localparam int OP_W    = 2;
    localparam int PAGE_FW = 10;
    localparam int OFS_W   = 10;
    localparam int CNT_W   = 16;
    localparam int CHG_W   = 2;

    // A range bound runs from 0 up to and including PAGE_SAMPLES.
    localparam int POS_W  = $clog2(PAGE_SAMPLES + 1);
    localparam int PAGE_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

    localparam logic [OP_W-1:0] OP_MARK  = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
    localparam logic [OP_W-1:0] OP_INVAL = 2'd2;

    localparam logic [CHG_W-1:0] CHG_NONE      = 2'd0;
    localparam logic [CHG_W-1:0] CHG_UPDATED   = 2'd1;
    localparam logic [CHG_W-1:0] CHG_B_DROPPED = 2'd2;

    typedef logic [POS_W-1:0] pos_t;

    typedef struct packed {
        pos_t a_start;
        pos_t a_end;
        pos_t b_start;
        pos_t b_end;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_wr;
        logic load;
        logic prep;
        logic calc;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
    } status_t;

endpackage

`default_nettype wire

FILE: rtl/pvrt_ctrl.sv
// ----------------------------------------------------------------------------
// pvrt_ctrl
// Sequencer: clearing pass after reset, then accept, read, update per item.
// ----------------------------------------------------------------------------
`default_nettype none
`include "page_valid_range_tracker_assert.svh"

module pvrt_ctrl
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  pvrt_pkg::status_t     status,
    output pvrt_pkg::cmd_t        cmd,
    output logic                  busy,
    output logic                  done
);
    import pvrt_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_READ  = 4'b0100,
        ST_CALC  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    assign done_next = (state_reg == ST_CALC);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign cmd.clear_wr = (state_reg == ST_CLEAR);
    assign cmd.load     = (state_reg == ST_IDLE) && start;
    assign cmd.prep     = (state_reg == ST_READ);
    assign cmd.calc     = (state_reg == ST_CALC);

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

    `PVRT_ASSERT_NEXT(a_accept_reads, start && !busy, state_reg == ST_READ,
                      "accepted transaction did not move on to the table read")
    `PVRT_ASSERT_NEXT(a_done_follows_calc, state_reg == ST_CALC, done && !busy,
                      "result strobe missing after the update cycle")
    `PVRT_ASSERT_NEXT(a_done_single, done, !done,
                      "result strobe lasted more than one cycle")
    `PVRT_ASSERT_SAME(a_no_done_in_clear, state_reg == ST_CLEAR, !done && !cmd.load,
                      "activity seen during the clearing pass")

endmodule

`default_nettype wire

FILE: rtl/pvrt_datapath.sv
// ----------------------------------------------------------------------------
// pvrt_datapath
// Page range table, request registers and the mark/query/invalidate update.
// ----------------------------------------------------------------------------
`default_nettype none

module pvrt_datapath
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  pvrt_pkg::cmd_t                       cmd,
    output pvrt_pkg::status_t                    status,
    input  wire logic [pvrt_pkg::OP_W-1:0]       op,
    input  wire logic [pvrt_pkg::PAGE_FW-1:0]    page,
    input  wire logic [pvrt_pkg::OFS_W-1:0]      offset,
    input  wire logic [pvrt_pkg::CNT_W-1:0]      count_req,
    output logic [pvrt_pkg::POS_W-1:0]           covered,
    output logic [pvrt_pkg::CHG_W-1:0]           change
);
    import pvrt_pkg::*;

    entry_t page_mem [PAGE_COUNT];

    logic [PAGE_W-1:0]  clr_cnt_reg;
    logic [PAGE_W-1:0]  clr_cnt_next;

    logic [OP_W-1:0]    op_reg;
    logic [PAGE_FW-1:0] page_reg;
    logic [OFS_W-1:0]   offset_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               in_range_reg;
    entry_t             ent_reg;
    pos_t               n_reg;
    pos_t               e_reg;
    pos_t               covered_reg;
    logic [CHG_W-1:0]   change_reg;

    logic               in_range;
    pos_t               s_pos;
    pos_t               room;
    pos_t               n_val;
    pos_t               a0;
    pos_t               a1;
    pos_t               b0;
    pos_t               b1;
    entry_t             mark_ent;
    logic [CHG_W-1:0]   mark_chg;
    logic               b_taken;
    entry_t             inval_ent;
    logic               q_hit;
    pos_t               q_room;
    pos_t               q_len;
    entry_t             new_ent;
    logic               upd;
    pos_t               res_cov;
    logic [CHG_W-1:0]   res_chg;

    logic               mem_we;
    logic [PAGE_W-1:0]  mem_addr;
    entry_t             mem_wdata;

    // ---------------- clearing pass ----------------
    assign clr_cnt_next      = clr_cnt_reg + PAGE_W'(1);
    assign status.clear_last = (32'(clr_cnt_reg) == PAGE_COUNT - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear_wr)
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // ---------------- request capture ----------------
    assign in_range = (32'(page) < PAGE_COUNT) && (32'(offset) < PAGE_SAMPLES);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg       <= op;
            page_reg     <= page;
            offset_reg   <= offset;
            count_reg    <= count_req;
            in_range_reg <= in_range;
        end
    end

    // The clipped count and span end are prepared while the entry is read.
    assign s_pos = POS_W'(offset_reg);
    assign room  = POS_W'(PAGE_SAMPLES) - s_pos;
    assign n_val = (count_reg < CNT_W'(room)) ? count_reg[POS_W-1:0] : room;

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            n_reg <= n_val;
            e_reg <= s_pos + n_val;
        end
    end

    // ---------------- update logic ----------------
    assign a0 = ent_reg.a_start;
    assign a1 = ent_reg.a_end;
    assign b0 = ent_reg.b_start;
    assign b1 = ent_reg.b_end;

    always_comb
    begin
        mark_ent = ent_reg;
        mark_chg = CHG_UPDATED;
        b_taken  = 1'b0;
        if ((a0 <= s_pos && a1 >= e_reg) || (b0 <= s_pos && b1 >= e_reg))
        begin
            mark_chg = CHG_NONE;
        end
        else if (a1 == '0)
        begin
            mark_ent.a_start = s_pos;
            mark_ent.a_end   = e_reg;
        end
        else if (a0 <= e_reg && a1 >= e_reg)
        begin
            mark_ent.a_start = s_pos;
        end
        else if (a0 <= s_pos && a1 >= s_pos)
        begin
            // Growing A up to or past the start of B swallows B.
            if (b0 != '0 && e_reg >= b0)
            begin
                mark_ent.a_end   = b1;
                mark_ent.b_start = '0;
                mark_ent.b_end   = '0;
            end
            else
            begin
                mark_ent.a_end = e_reg;
            end
        end
        else
        begin
            if (b0 != '0)
            begin
                if (b0 <= e_reg && b1 >= e_reg)
                begin
                    mark_ent.b_start = s_pos;
                    b_taken          = 1'b1;
                end
                else if (b0 <= s_pos && b1 >= s_pos)
                begin
                    mark_ent.b_end = e_reg;
                    b_taken        = 1'b1;
                end
                else
                begin
                    mark_chg = CHG_B_DROPPED;
                end
            end
            if (!b_taken)
            begin
                if (a1 < s_pos)
                begin
                    mark_ent.b_start = s_pos;
                    mark_ent.b_end   = e_reg;
                end
                else
                begin
                    mark_ent.b_start = a0;
                    mark_ent.b_end   = a1;
                    mark_ent.a_start = s_pos;
                    mark_ent.a_end   = e_reg;
                end
            end
        end
    end

    always_comb
    begin
        inval_ent = ent_reg;
        if (a0 != '0 && s_pos <= a0)
        begin
            inval_ent = '0;
        end
        else if (s_pos < a1)
        begin
            inval_ent.a_end   = s_pos;
            inval_ent.b_start = '0;
            inval_ent.b_end   = '0;
        end
        else if (b0 != '0 && s_pos <= b0)
        begin
            inval_ent.b_start = '0;
            inval_ent.b_end   = '0;
        end
        else if (s_pos < b1)
        begin
            inval_ent.b_end = s_pos;
        end
    end

    always_comb
    begin
        q_hit  = 1'b1;
        q_room = '0;
        if (a0 <= s_pos && a1 > s_pos)
        begin
            q_room = a1 - s_pos;
        end
        else if (b0 <= s_pos && b1 > s_pos)
        begin
            q_room = b1 - s_pos;
        end
        else
        begin
            q_hit = 1'b0;
        end
    end

    assign q_len = (count_reg < CNT_W'(q_room)) ? count_reg[POS_W-1:0] : q_room;

    always_comb
    begin
        new_ent = ent_reg;
        upd     = 1'b0;
        res_cov = '0;
        res_chg = CHG_NONE;
        if (in_range_reg)
        begin
            case (op_reg)
                OP_MARK:
                begin
                    new_ent = mark_ent;
                    upd     = 1'b1;
                    res_cov = n_reg;
                    res_chg = mark_chg;
                end
                OP_QUERY:
                begin
                    res_cov = q_hit ? q_len : '0;
                end
                OP_INVAL:
                begin
                    new_ent = inval_ent;
                    upd     = 1'b1;
                end
                default:
                begin
                    upd = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.calc)
        begin
            covered_reg <= res_cov;
            change_reg  <= res_chg;
        end
    end

    assign covered = covered_reg;
    assign change  = change_reg;

    // ---------------- page table ----------------
    assign mem_we    = cmd.clear_wr || (cmd.calc && upd);
    assign mem_addr  = cmd.clear_wr ? clr_cnt_reg : page_reg[PAGE_W-1:0];
    assign mem_wdata = cmd.clear_wr ? '0 : new_ent;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            page_mem[mem_addr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ent_reg <= page_mem[page[PAGE_W-1:0]];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/page_valid_range_tracker.sv
// ----------------------------------------------------------------------------
// page_valid_range_tracker
// Per-page record of up to two valid sample ranges with mark, query and
// invalidate operations.
// ----------------------------------------------------------------------------
// After reset the block holds busy high while it clears the page table, one
// page per cycle. It then takes a transaction on any cycle with start high
// and busy low, and finishes it in steps: the accept edge reads the page
// entry, the READ state clips the count, the CALC state updates and writes
// the entry back. Busy stays high until the write-back is done, so a new
// transaction is only taken once the last one has finished.
// Done is high for exactly one cycle, in the cycle after the write-back, and
// covered and change hold the result while it is high; the receiver cannot
// hold it off and must take it then.
`default_nettype none

module page_valid_range_tracker
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [pvrt_pkg::OP_W-1:0]       op,
    input  wire logic [pvrt_pkg::PAGE_FW-1:0]    page,
    input  wire logic [pvrt_pkg::OFS_W-1:0]      offset,
    input  wire logic [pvrt_pkg::CNT_W-1:0]      count_req,
    output logic                                 done,
    output logic [pvrt_pkg::POS_W-1:0]           covered,
    output logic [pvrt_pkg::CHG_W-1:0]           change
);
    import pvrt_pkg::*;

    cmd_t    cmd;
    status_t status;

    pvrt_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    pvrt_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .op        (op),
        .page      (page),
        .offset    (offset),
        .count_req (count_req),
        .covered   (covered),
        .change    (change)
    );

endmodule

`default_nettype wire
